// ----- rtl/ffa_pkg.sv -----
// ----------------------------------------------------------------------------
// ffa_pkg
// shared types, constants and helpers for the first-fit arena allocator
// ----------------------------------------------------------------------------
package ffa_pkg;

    // arena geometry
    localparam int ARENA_BYTES = 4096;
    localparam int HDR_BYTES   = 2;
    localparam int ADDR_W      = $clog2(ARENA_BYTES);
    localparam int POS_W       = ADDR_W + 1;
    // header word: free bit on top of the payload size
    localparam int WORD_W      = ADDR_W + 1;

    // last offset at which a header still fits, also the largest payload
    localparam logic [POS_W-1:0] MAX_POS = POS_W'(ARENA_BYTES - HDR_BYTES);
    localparam logic [POS_W-1:0] HDR_POS = POS_W'(HDR_BYTES);

    // request kinds
    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    // result status codes
    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_TOO_LARGE    = 3'd1,
        ST_NO_SPACE     = 3'd2,
        ST_NOT_ALLOC    = 3'd3,
        ST_ALREADY_FREE = 3'd4
    } t_status;

    // shared unit operations
    typedef enum logic {
        ALU_ADD2 = 1'b0,
        ALU_SUB  = 1'b1
    } t_alu_op;

    // sequencer states
    typedef enum logic [4:0] {
        S_INIT,
        S_IDLE,
        S_A_RD,
        S_A_CHK,
        S_A_NXT,
        S_A_SPL,
        S_A_SPW,
        S_A_MRK,
        S_F_RD,
        S_F_ADV,
        S_F_CHK,
        S_F_MP,
        S_F_AB,
        S_F_AB_RD,
        S_F_AB_CHK,
        S_DONE
    } t_state;

    // header memory write request
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [WORD_W-1:0] data;
    } t_ram_wr;

    // true when a header placed at pos lies wholly inside the arena
    function automatic logic hdr_fits(input logic [POS_W-1:0] pos);
        return pos <= MAX_POS;
    endfunction

endpackage

// ----- rtl/ffa_hdr_ram.sv -----
// ----------------------------------------------------------------------------
// ffa_hdr_ram
// header memory, one word per byte offset, one write and one registered read
// ----------------------------------------------------------------------------
module ffa_hdr_ram (
    input  logic                       i_clk,
    input  ffa_pkg::t_ram_wr           i_wr,
    input  logic [ffa_pkg::ADDR_W-1:0] i_raddr,
    output logic [ffa_pkg::WORD_W-1:0] o_rdata
);

    logic [ffa_pkg::WORD_W-1:0] r_mem [ffa_pkg::ARENA_BYTES];
    logic [ffa_pkg::WORD_W-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/ffa_alu.sv -----
// ----------------------------------------------------------------------------
// ffa_alu
// shared add/subtract unit: step over a header or compare two offsets
// ----------------------------------------------------------------------------
module ffa_alu (
    input  ffa_pkg::t_alu_op          i_op,
    input  logic [ffa_pkg::POS_W-1:0] i_a,
    input  logic [ffa_pkg::POS_W-1:0] i_b,
    output logic [ffa_pkg::POS_W-1:0] o_res,
    output logic                      o_borrow,
    output logic                      o_zero
);

    logic [ffa_pkg::POS_W:0] sum;

    // a + b + header bytes, or a - b with borrow out
    always_comb begin
        unique case (i_op)
            ffa_pkg::ALU_ADD2: sum = {1'b0, i_a} + {1'b0, i_b} + {1'b0, ffa_pkg::HDR_POS};
            ffa_pkg::ALU_SUB:  sum = {1'b0, i_a} - {1'b0, i_b};
            default:           sum = '0;
        endcase
    end

    assign o_res    = sum[ffa_pkg::POS_W-1:0];
    assign o_borrow = (i_op == ffa_pkg::ALU_SUB) && sum[ffa_pkg::POS_W];
    assign o_zero   = (o_res == '0);

endmodule

// ----- rtl/first_fit_arena_allocator.sv -----
// steps: a request is taken in idle; allocate then reads and tests each used header,
//   steps over each free header too small, splits and marks the fitting one or marks it
//   whole, and hands over; free reads and steps over each header before the target, finds
//   and marks it, joins back, absorbs each free neighbor, ends, and hands over
// throughput: one request at a time, the next is taken once the result is registered
// reset: after reset the block writes the initial free header, then the block is ready
// ----------------------------------------------------------------------------
// first_fit_arena_allocator
// first-fit allocator over an implicit list of 2-byte headers in a 4 KiB arena,
// walked one header per memory read by a small sequencer and a shared adder
// ----------------------------------------------------------------------------
module first_fit_arena_allocator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [23:0] i_s_axis_tdata,  // request_size[11:0], block_address[23:12]
    input  logic        i_s_axis_tuser,  // kind[0]
    // result stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata   // status[2:0], result_address[14:3], zero[15]
);

    localparam int AW = ffa_pkg::ADDR_W;
    localparam int PW = ffa_pkg::POS_W;
    localparam int WW = ffa_pkg::WORD_W;

    ffa_pkg::t_state  r_state, n_state;
    logic [AW-1:0]    r_req, n_req;
    logic [AW-1:0]    r_target, n_target;
    logic [PW-1:0]    r_pos, n_pos;
    logic [AW-1:0]    r_size, n_size;
    logic [AW-1:0]    r_rem, n_rem;
    logic [AW-1:0]    r_addr, n_addr;
    logic [AW-1:0]    r_prev, n_prev;
    logic [AW-1:0]    r_prev_size, n_prev_size;
    logic             r_prev_free, n_prev_free;
    logic             r_have_prev, n_have_prev;
    logic [AW-1:0]    r_cur, n_cur;
    logic [AW-1:0]    r_cur_size, n_cur_size;
    ffa_pkg::t_status r_status, n_status;
    logic [AW-1:0]    r_res, n_res;
    logic             r_out_valid, n_out_valid;
    ffa_pkg::t_status r_out_status, n_out_status;
    logic [AW-1:0]    r_out_addr, n_out_addr;

    ffa_pkg::t_ram_wr ram_wr;
    logic [WW-1:0]    rdata;
    logic             rd_free;
    logic [AW-1:0]    rd_size;

    ffa_pkg::t_alu_op alu_op;
    logic [PW-1:0]    alu_a, alu_b, alu_res;
    logic             alu_borrow, alu_zero;

    logic [AW-1:0]    in_req, in_addr;

    assign in_req  = i_s_axis_tdata[AW-1:0];
    assign in_addr = i_s_axis_tdata[2*AW-1:AW];
    assign rd_free = rdata[AW];
    assign rd_size = rdata[AW-1:0];

    // header memory
    ffa_hdr_ram u_ram (
        .i_clk   (i_clk),
        .i_wr    (ram_wr),
        .i_raddr (r_pos[AW-1:0]),
        .o_rdata (rdata)
    );

    // shared adder
    ffa_alu u_alu (
        .i_op     (alu_op),
        .i_a      (alu_a),
        .i_b      (alu_b),
        .o_res    (alu_res),
        .o_borrow (alu_borrow),
        .o_zero   (alu_zero)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ffa_pkg::S_INIT;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // working and payload registers
    always_ff @(posedge i_clk) begin
        r_req        <= n_req;
        r_target     <= n_target;
        r_pos        <= n_pos;
        r_size       <= n_size;
        r_rem        <= n_rem;
        r_addr       <= n_addr;
        r_prev       <= n_prev;
        r_prev_size  <= n_prev_size;
        r_prev_free  <= n_prev_free;
        r_have_prev  <= n_have_prev;
        r_cur        <= n_cur;
        r_cur_size   <= n_cur_size;
        r_status     <= n_status;
        r_res        <= n_res;
        r_out_status <= n_out_status;
        r_out_addr   <= n_out_addr;
    end

    // sequencer: next state, shared unit operands, memory writes
    always_comb begin
        n_state      = r_state;
        n_req        = r_req;
        n_target     = r_target;
        n_pos        = r_pos;
        n_size       = r_size;
        n_rem        = r_rem;
        n_addr       = r_addr;
        n_prev       = r_prev;
        n_prev_size  = r_prev_size;
        n_prev_free  = r_prev_free;
        n_have_prev  = r_have_prev;
        n_cur        = r_cur;
        n_cur_size   = r_cur_size;
        n_status     = r_status;
        n_res        = r_res;
        n_out_status = r_out_status;
        n_out_addr   = r_out_addr;
        // result leaves on a transfer
        n_out_valid  = r_out_valid && !i_m_axis_tready;

        alu_op      = ffa_pkg::ALU_ADD2;
        alu_a       = r_pos;
        alu_b       = {1'b0, r_size};
        ram_wr.we   = 1'b0;
        ram_wr.addr = r_pos[AW-1:0];
        ram_wr.data = {1'b0, r_size};

        unique case (r_state)
            // lay down the single free block
            ffa_pkg::S_INIT: begin
                ram_wr.we   = 1'b1;
                ram_wr.addr = '0;
                ram_wr.data = {1'b1, ffa_pkg::MAX_POS[AW-1:0]};
                n_state     = ffa_pkg::S_IDLE;
            end

            // take a request
            ffa_pkg::S_IDLE: begin
                alu_op = ffa_pkg::ALU_SUB;
                if (i_s_axis_tuser == ffa_pkg::KIND_ALLOC) begin
                    alu_a = ffa_pkg::MAX_POS;
                    alu_b = {1'b0, in_req};
                end else begin
                    alu_a = {1'b0, in_addr};
                    alu_b = ffa_pkg::HDR_POS;
                end
                if (i_s_axis_tvalid) begin
                    n_pos       = '0;
                    n_have_prev = 1'b0;
                    n_req       = in_req;
                    n_target    = alu_res[AW-1:0];
                    n_res       = '0;
                    if (i_s_axis_tuser == ffa_pkg::KIND_ALLOC) begin
                        if (alu_borrow) begin
                            n_status = ffa_pkg::ST_TOO_LARGE;
                            n_state  = ffa_pkg::S_DONE;
                        end else begin
                            n_state  = ffa_pkg::S_A_RD;
                        end
                    end else begin
                        if (alu_borrow) begin
                            n_status = ffa_pkg::ST_NOT_ALLOC;
                            n_state  = ffa_pkg::S_DONE;
                        end else begin
                            n_state  = ffa_pkg::S_F_RD;
                        end
                    end
                end
            end

            // allocate: fetch the header at the walk position
            ffa_pkg::S_A_RD: begin
                if (!ffa_pkg::hdr_fits(r_pos)) begin
                    n_status = ffa_pkg::ST_NO_SPACE;
                    n_res    = '0;
                    n_state  = ffa_pkg::S_DONE;
                end else begin
                    n_state  = ffa_pkg::S_A_CHK;
                end
            end

            // allocate: test the header, step over it when used
            ffa_pkg::S_A_CHK: begin
                n_size = rd_size;
                if (rd_free) begin
                    alu_op = ffa_pkg::ALU_SUB;
                    alu_a  = {1'b0, rd_size};
                    alu_b  = {1'b0, r_req};
                    n_rem  = alu_res[AW-1:0];
                    if (alu_borrow) begin
                        n_state = ffa_pkg::S_A_NXT;
                    end else if (alu_res[AW-1:1] != '0) begin
                        n_state = ffa_pkg::S_A_SPL;
                    end else begin
                        n_state = ffa_pkg::S_A_MRK;
                    end
                end else begin
                    alu_b   = {1'b0, rd_size};
                    n_pos   = alu_res;
                    n_state = ffa_pkg::S_A_RD;
                end
            end

            // allocate: free block too small, step over it
            ffa_pkg::S_A_NXT: begin
                n_pos   = alu_res;
                n_state = ffa_pkg::S_A_RD;
            end

            // allocate: offset of the split-off remainder
            ffa_pkg::S_A_SPL: begin
                alu_b   = {1'b0, r_req};
                n_addr  = alu_res[AW-1:0];
                n_state = ffa_pkg::S_A_SPW;
            end

            // allocate: write the remainder header
            ffa_pkg::S_A_SPW: begin
                alu_op      = ffa_pkg::ALU_SUB;
                alu_a       = {1'b0, r_rem};
                alu_b       = ffa_pkg::HDR_POS;
                ram_wr.we   = 1'b1;
                ram_wr.addr = r_addr;
                ram_wr.data = {1'b1, alu_res[AW-1:0]};
                n_size      = r_req;
                n_state     = ffa_pkg::S_A_MRK;
            end

            // allocate: mark the block used, payload offset out
            ffa_pkg::S_A_MRK: begin
                alu_b       = '0;
                ram_wr.we   = 1'b1;
                ram_wr.addr = r_pos[AW-1:0];
                ram_wr.data = {1'b0, r_size};
                n_res       = alu_res[AW-1:0];
                n_status    = ffa_pkg::ST_OK;
                n_state     = ffa_pkg::S_DONE;
            end

            // free: compare the walk position with the target header
            ffa_pkg::S_F_RD: begin
                alu_op = ffa_pkg::ALU_SUB;
                alu_a  = {1'b0, r_target};
                alu_b  = r_pos;
                if (!ffa_pkg::hdr_fits(r_pos) || alu_borrow) begin
                    n_status = ffa_pkg::ST_NOT_ALLOC;
                    n_res    = '0;
                    n_state  = ffa_pkg::S_DONE;
                end else if (alu_zero) begin
                    n_state  = ffa_pkg::S_F_CHK;
                end else begin
                    n_state  = ffa_pkg::S_F_ADV;
                end
            end

            // free: remember this header as previous, step over it
            ffa_pkg::S_F_ADV: begin
                alu_b       = {1'b0, rd_size};
                n_prev      = r_pos[AW-1:0];
                n_prev_size = rd_size;
                n_prev_free = rd_free;
                n_have_prev = 1'b1;
                n_pos       = alu_res;
                n_state     = ffa_pkg::S_F_RD;
            end

            // free: reject a double free, else mark the block free
            ffa_pkg::S_F_CHK: begin
                if (rd_free) begin
                    n_status = ffa_pkg::ST_ALREADY_FREE;
                    n_res    = '0;
                    n_state  = ffa_pkg::S_DONE;
                end else begin
                    ram_wr.we   = 1'b1;
                    ram_wr.addr = r_pos[AW-1:0];
                    ram_wr.data = {1'b1, rd_size};
                    n_size      = rd_size;
                    n_cur       = r_pos[AW-1:0];
                    n_cur_size  = rd_size;
                    if (r_have_prev && r_prev_free) begin
                        n_state = ffa_pkg::S_F_MP;
                    end else begin
                        n_state = ffa_pkg::S_F_AB;
                    end
                end
            end

            // free: join with the free block before it
            ffa_pkg::S_F_MP: begin
                alu_a       = {1'b0, r_prev_size};
                alu_b       = {1'b0, r_size};
                ram_wr.we   = 1'b1;
                ram_wr.addr = r_prev;
                ram_wr.data = {1'b1, alu_res[AW-1:0]};
                n_cur       = r_prev;
                n_cur_size  = alu_res[AW-1:0];
                n_state     = ffa_pkg::S_F_AB;
            end

            // free: offset of the following header
            ffa_pkg::S_F_AB: begin
                alu_a   = {1'b0, r_cur};
                alu_b   = {1'b0, r_cur_size};
                n_pos   = alu_res;
                n_state = ffa_pkg::S_F_AB_RD;
            end

            // free: fetch the following header if it lies in the arena
            ffa_pkg::S_F_AB_RD: begin
                if (!ffa_pkg::hdr_fits(r_pos)) begin
                    n_status = ffa_pkg::ST_OK;
                    n_res    = r_cur;
                    n_state  = ffa_pkg::S_DONE;
                end else begin
                    n_state  = ffa_pkg::S_F_AB_CHK;
                end
            end

            // free: absorb a following free block
            ffa_pkg::S_F_AB_CHK: begin
                alu_a = {1'b0, r_cur_size};
                alu_b = {1'b0, rd_size};
                if (rd_free) begin
                    ram_wr.we   = 1'b1;
                    ram_wr.addr = r_cur;
                    ram_wr.data = {1'b1, alu_res[AW-1:0]};
                    n_cur_size  = alu_res[AW-1:0];
                    n_state     = ffa_pkg::S_F_AB;
                end else begin
                    n_status = ffa_pkg::ST_OK;
                    n_res    = r_cur;
                    n_state  = ffa_pkg::S_DONE;
                end
            end

            // hand the result to the output register once it is free
            ffa_pkg::S_DONE: begin
                if (!r_out_valid || i_m_axis_tready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_addr   = r_res;
                    n_state      = ffa_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = ffa_pkg::S_IDLE;
            end
        endcase
    end

    // stream ports
    assign o_s_axis_tready = (r_state == ffa_pkg::S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {1'b0, r_out_addr, r_out_status};

endmodule

// ----- tb/ffa_result_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffa_result_checker
// watches the request and result streams of the first-fit arena allocator,
// keeps its own shadow copy of the header chain, works out the outcome of
// every accepted request and compares each result transfer against it
// ----------------------------------------------------------------------------
module ffa_result_checker
    import ffa_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request stream
    input  logic        i_req_tvalid,
    input  logic        i_req_tready,
    input  logic [23:0] i_req_tdata,   // request_size[11:0], block_address[23:12]
    input  logic        i_req_tuser,   // kind[0]
    // result stream
    input  logic        i_rsp_tvalid,
    input  logic        i_rsp_tready,
    input  logic [15:0] i_rsp_tdata,   // status[2:0], result_address[14:3], zero[15]
    // totals for the verdict
    output int unsigned o_fail_count,
    output int unsigned o_open_count
);

    // one shadow header per byte offset
    typedef struct packed {
        logic              is_free;
        logic [ADDR_W-1:0] size;
    } t_shadow_hdr;

    // outcome of one request as the block should report it
    typedef struct packed {
        t_status           status;
        logic [ADDR_W-1:0] addr;
    } t_outcome;

    t_shadow_hdr shadow_hdr [ARENA_BYTES];
    t_outcome    pending_outcomes [$];

    // offset of the header that follows the one at pos
    function automatic logic [POS_W-1:0] next_hdr(input logic [POS_W-1:0] pos);
        return pos + HDR_POS + POS_W'(shadow_hdr[pos].size);
    endfunction

    // apply one request to the shadow chain and return its outcome
    function automatic t_outcome arena_outcome(input logic kind,
                                               input logic [ADDR_W-1:0] req,
                                               input logic [ADDR_W-1:0] addr);
        t_outcome          res;
        logic [POS_W-1:0]  pos;
        logic [POS_W-1:0]  prev;
        logic [POS_W-1:0]  target;
        logic [POS_W-1:0]  nxt;
        logic [ADDR_W-1:0] size;
        logic              found;
        logic              have_prev;
        res.status = ST_OK;
        res.addr   = '0;
        pos        = '0;
        prev       = '0;
        found      = 1'b0;
        have_prev  = 1'b0;
        if (kind == KIND_ALLOC) begin
            if (POS_W'(req) > MAX_POS) begin
                res.status = ST_TOO_LARGE;
            end else begin
                // first-fit walk over the chain
                while (!found && pos <= MAX_POS) begin
                    if (shadow_hdr[pos].is_free && shadow_hdr[pos].size >= req)
                        found = 1'b1;
                    else
                        pos = next_hdr(pos);
                end
                if (!found) begin
                    res.status = ST_NO_SPACE;
                end else begin
                    size = shadow_hdr[pos].size;
                    // split only when the rest can hold a header
                    if (size - req >= ADDR_W'(HDR_BYTES)) begin
                        nxt = pos + HDR_POS + POS_W'(req);
                        shadow_hdr[nxt] = '{is_free: 1'b1,
                                            size: size - req - ADDR_W'(HDR_BYTES)};
                        size = req;
                    end
                    shadow_hdr[pos] = '{is_free: 1'b0, size: size};
                    // payload offset wraps to 12 bits at the arena end
                    res.addr = ADDR_W'(pos + HDR_POS);
                end
            end
        end else begin
            // look for the header two bytes below the payload offset
            if (POS_W'(addr) >= HDR_POS) begin
                target = POS_W'(addr) - HDR_POS;
                while (!found && pos <= MAX_POS && pos <= target) begin
                    if (pos == target) begin
                        found = 1'b1;
                    end else begin
                        prev      = pos;
                        have_prev = 1'b1;
                        pos       = next_hdr(pos);
                    end
                end
            end
            if (!found) begin
                res.status = ST_NOT_ALLOC;
            end else if (shadow_hdr[pos].is_free) begin
                res.status = ST_ALREADY_FREE;
            end else begin
                shadow_hdr[pos].is_free = 1'b1;
                // join with a free block just before
                if (have_prev && shadow_hdr[prev].is_free) begin
                    shadow_hdr[prev].size = shadow_hdr[prev].size + shadow_hdr[pos].size
                                            + ADDR_W'(HDR_BYTES);
                    pos = prev;
                end
                // absorb the run of free blocks that follow
                nxt = next_hdr(pos);
                while (nxt <= MAX_POS && shadow_hdr[nxt].is_free) begin
                    shadow_hdr[pos].size = shadow_hdr[pos].size + shadow_hdr[nxt].size
                                           + ADDR_W'(HDR_BYTES);
                    nxt = next_hdr(pos);
                end
                res.addr = pos[ADDR_W-1:0];
            end
        end
        return res;
    endfunction

    // track requests and compare results
    always @(posedge i_clk) begin
        t_outcome          want;
        logic [2:0]        got_status;
        logic [ADDR_W-1:0] got_addr;
        if (!i_rst_n) begin
            for (int i = 0; i < ARENA_BYTES; i++)
                shadow_hdr[i] = '0;
            shadow_hdr[0] = '{is_free: 1'b1, size: ADDR_W'(ARENA_BYTES - HDR_BYTES)};
            pending_outcomes.delete();
        end else begin
            if (i_req_tvalid && i_req_tready)
                pending_outcomes.push_back(arena_outcome(i_req_tuser, i_req_tdata[11:0],
                                                         i_req_tdata[23:12]));
            if (i_rsp_tvalid && i_rsp_tready) begin
                got_status = i_rsp_tdata[2:0];
                got_addr   = i_rsp_tdata[14:3];
                if (pending_outcomes.size() == 0) begin
                    $display("%0t: result transfer with nothing outstanding, expected none, "
                             , $time, "actual status %0d address %0d", got_status, got_addr);
                    o_fail_count = o_fail_count + 1;
                end else begin
                    want = pending_outcomes.pop_front();
                    if (got_status !== want.status) begin
                        $display("%0t: status mismatch, expected %0d actual %0d",
                                 $time, want.status, got_status);
                        o_fail_count = o_fail_count + 1;
                    end
                    if (got_addr !== want.addr) begin
                        $display("%0t: address mismatch, expected %0d actual %0d",
                                 $time, want.addr, got_addr);
                        o_fail_count = o_fail_count + 1;
                    end
                    if (i_rsp_tdata[15] !== 1'b0) begin
                        $display("%0t: padding bit mismatch, expected 0 actual %b",
                                 $time, i_rsp_tdata[15]);
                        o_fail_count = o_fail_count + 1;
                    end
                end
            end
        end
        o_open_count <= pending_outcomes.size();
    end

endmodule

// ----- tb/tb_first_fit_arena_allocator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_first_fit_arena_allocator
// drives allocate and free requests into the arena allocator: a directed
// pass over the corner cases, then mostly well-formed random traffic that
// frees blocks it was handed, mixed with bad addresses and double frees;
// both streams stall in random bursts, the checker does the comparing
// ----------------------------------------------------------------------------
module tb_first_fit_arena_allocator;
    import ffa_pkg::*;

    localparam int RANDOM_ITEMS = 1600;
    localparam int CALM_ITEMS   = 150;
    localparam int MAX_LIVE     = 40;
    localparam int DRAIN_CYCLES = 400;

    logic        clk     = 1'b0;
    logic        rst_n   = 1'b0;
    logic        s_valid = 1'b0;
    logic [23:0] s_data  = '0;
    logic        s_user  = 1'b0;
    logic        m_ready = 1'b1;
    logic        calm    = 1'b0;
    wire         s_ready;
    wire         m_valid;
    wire  [15:0] m_data;

    int unsigned fail_count;
    int unsigned open_count;
    int unsigned ready_hold = 0;

    // addresses handed out and not yet freed, and recent frees for repeats
    logic [ADDR_W-1:0] live_addrs [$];
    logic [ADDR_W-1:0] freed_addrs [$];
    logic              sent_kinds [$];

    first_fit_arena_allocator dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data)
    );

    ffa_result_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_req_tvalid (s_valid),
        .i_req_tready (s_ready),
        .i_req_tdata  (s_data),
        .i_req_tuser  (s_user),
        .i_rsp_tvalid (m_valid),
        .i_rsp_tready (m_ready),
        .i_rsp_tdata  (m_data),
        .o_fail_count (fail_count),
        .o_open_count (open_count)
    );

    // clock
    initial begin
        forever #4 clk = ~clk;
    end

    // overall limit, far above the slowest run of this traffic
    initial begin
        #50_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // result side stalls in random bursts
    always @(negedge clk) begin
        if (calm) begin
            m_ready    <= 1'b1;
            ready_hold <= 0;
        end else if (ready_hold != 0) begin
            m_ready    <= 1'b0;
            ready_hold <= ready_hold - 1;
        end else if ($urandom_range(0, 7) == 0) begin
            m_ready    <= 1'b0;
            ready_hold <= $urandom_range(0, 10);
        end else begin
            m_ready <= 1'b1;
        end
    end

    // remember which allocations succeeded so later frees can target them
    always @(posedge clk) begin
        if (rst_n) begin
            if (s_valid && s_ready)
                sent_kinds.push_back(s_user);
            if (m_valid && m_ready && sent_kinds.size() != 0) begin
                if (sent_kinds.pop_front() == KIND_ALLOC && m_data[2:0] == ST_OK)
                    live_addrs.push_back(m_data[14:3]);
            end
        end
    end

    // one request transfer, then maybe an idle burst
    task automatic push_request(input logic kind, input logic [ADDR_W-1:0] req,
                                input logic [ADDR_W-1:0] addr);
        int unsigned gap;
        @(negedge clk);
        s_valid <= 1'b1;
        s_user  <= kind;
        s_data  <= {addr, req};
        do @(posedge clk); while (!s_ready);
        if (!calm && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 11);
            @(negedge clk);
            s_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    // random request; frees mostly target blocks actually handed out
    task automatic random_request();
        int unsigned       pick;
        int unsigned       idx;
        logic              kind;
        logic [ADDR_W-1:0] req;
        logic [ADDR_W-1:0] addr;
        pick = $urandom_range(0, 99);
        kind = (live_addrs.size() > MAX_LIVE) ? (pick < 80) : (pick < 45);
        req  = ADDR_W'($urandom);
        addr = ADDR_W'($urandom);
        pick = $urandom_range(0, 99);
        if (kind == KIND_ALLOC) begin
            if (pick < 65)
                req = ADDR_W'($urandom_range(0, 48));
            else if (pick < 85)
                req = ADDR_W'($urandom_range(49, 400));
            else if (pick < 93)
                req = ADDR_W'($urandom);
            else if (pick < 97)
                req = ADDR_W'($urandom_range(1800, 4094));
            else
                req = ADDR_W'($urandom_range(4093, 4095));
        end else if (pick < 75 && live_addrs.size() != 0) begin
            idx  = $urandom_range(0, live_addrs.size() - 1);
            addr = live_addrs[idx];
            live_addrs.delete(idx);
            freed_addrs.push_back(addr);
            if (freed_addrs.size() > 16)
                void'(freed_addrs.pop_front());
        end else if (pick < 85 && freed_addrs.size() != 0) begin
            // double free, or a free of a block since merged away
            addr = freed_addrs[$urandom_range(0, freed_addrs.size() - 1)];
        end else if (pick < 92 && live_addrs.size() != 0) begin
            // near miss around a real payload offset
            addr = live_addrs[$urandom_range(0, live_addrs.size() - 1)];
            if ($urandom_range(0, 1) == 0)
                addr = addr + ADDR_W'($urandom_range(1, 3));
            else
                addr = addr - ADDR_W'($urandom_range(1, 3));
        end
        push_request(kind, req, addr);
    endtask

    // stimulus
    initial begin
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        // oversized, whole arena, then full
        push_request(KIND_ALLOC, 12'd4095, 12'd0);
        push_request(KIND_ALLOC, 12'd4094, 12'd4095);
        push_request(KIND_ALLOC, 12'd0, 12'd0);
        // free, double free, bad addresses
        push_request(KIND_FREE, 12'd4095, 12'd2);
        push_request(KIND_FREE, 12'd0, 12'd2);
        push_request(KIND_FREE, 12'd0, 12'd0);
        push_request(KIND_FREE, 12'd0, 12'd1);
        push_request(KIND_FREE, 12'd0, 12'd4095);
        // remainder of one byte hands over the whole block
        push_request(KIND_ALLOC, 12'd4093, 12'd0);
        push_request(KIND_FREE, 12'd0, 12'd2);
        // remainder of two bytes leaves a header-only block at the end
        push_request(KIND_ALLOC, 12'd4092, 12'd0);
        // zero-size request there wraps the payload offset to zero
        push_request(KIND_ALLOC, 12'd0, 12'd0);
        push_request(KIND_FREE, 12'd0, 12'd0);
        push_request(KIND_FREE, 12'd0, 12'd2);
        // small blocks, then frees joining backward and forward
        push_request(KIND_ALLOC, 12'd0, 12'd0);
        push_request(KIND_ALLOC, 12'd10, 12'd0);
        push_request(KIND_ALLOC, 12'd20, 12'd0);
        push_request(KIND_FREE, 12'd0, 12'd4);
        push_request(KIND_FREE, 12'd0, 12'd2);
        push_request(KIND_FREE, 12'd0, 12'd16);
        // offsets that are not on the chain
        push_request(KIND_FREE, 12'd0, 12'd3);
        push_request(KIND_FREE, 12'd0, 12'd100);
        push_request(KIND_FREE, 12'd0, 12'd4094);
        push_request(KIND_ALLOC, 12'd4093, 12'd0);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS - CALM_ITEMS)
                calm <= 1'b1;
            random_request();
        end
        @(negedge clk);
        s_valid <= 1'b0;

        // drain, then let the block settle
        wait (open_count == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && open_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
